@@ rtl/tscf_pkg.sv @@
// Shared types, constants and the character encoder of the text stream filter.
`default_nettype none

package tscf_pkg;

    // Width of the printed line number field; the counter holds as many BCD digits.
    localparam int NUM_DIGITS = 6;
    localparam int CNT_W      = 4 * NUM_DIGITS;

    // Positions of one item's output sequence: digits, tab, dollar, up to four char bytes.
    localparam int POS_TAB = NUM_DIGITS;
    localparam int POS_DOL = NUM_DIGITS + 1;
    localparam int POS_CHR = NUM_DIGITS + 2;
    localparam int POS_N   = NUM_DIGITS + 6;
    localparam int POS_W   = $clog2(POS_N);

    // Job queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration register indexes.
    localparam logic [2:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [2:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [2:0] REG_SHOW_TABS        = 3'd3;
    localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd4;

    // Numbering modes.
    localparam logic [1:0] NUM_NONE     = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UPPER_I = 8'h49;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_HIGH   = 8'h80;
    localparam logic [7:0] CH_HIGH_PRINT = 8'hA0;
    localparam logic [7:0] CH_HIGH_DEL = 8'hFF;
    localparam logic [7:0] CARET_OFS = 8'h40;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } cfg_t;

    // Encoded character: bytes in order from b[0], last is the index of the final byte.
    typedef struct packed {
        logic [1:0]      last;
        logic [3:0][7:0] b;
    } chr_t;

    typedef struct packed {
        logic             num_en;
        logic [CNT_W-1:0] count;
        logic             dollar;
        chr_t             chr;
    } job_t;

    function automatic chr_t enc_char(input logic [7:0] c, input logic tabs,
                                      input logic np);
        chr_t r;
        r.last = 2'd0;
        r.b    = '0;
        r.b[0] = c;
        if (tabs && c == CH_TAB) begin
            r.last = 2'd1;
            r.b[0] = CH_CARET;
            r.b[1] = CH_UPPER_I;
        end else if (np) begin
            if (c == CH_TAB || c == CH_NL || (c >= CH_SPACE && c < CH_DEL)) begin
                r.last = 2'd0;
            end else if (c == CH_DEL) begin
                r.last = 2'd1;
                r.b[0] = CH_CARET;
                r.b[1] = CH_QMARK;
            end else if (c >= CH_HIGH_PRINT) begin
                r.b[0] = CH_UPPER_M;
                r.b[1] = CH_DASH;
                if (c != CH_HIGH_DEL) begin
                    r.last = 2'd2;
                    r.b[2] = c - CH_HIGH;
                end else begin
                    r.last = 2'd3;
                    r.b[2] = CH_CARET;
                    r.b[3] = CH_QMARK;
                end
            end else if (c >= CH_HIGH) begin
                r.last = 2'd3;
                r.b[0] = CH_UPPER_M;
                r.b[1] = CH_DASH;
                r.b[2] = CH_CARET;
                r.b[3] = c - CARET_OFS;
            end else begin
                r.last = 2'd1;
                r.b[0] = CH_CARET;
                r.b[1] = c + CARET_OFS;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tscf_front.sv @@
// Front end: configuration registers, per-line state and job classification.
`default_nettype none

module tscf_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [1:0]           cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_data_byte,
    input  wire logic                 s_file_start,
    input  wire logic                 s_first_file,
    input  wire logic                 q_full,
    output logic                      q_push,
    output tscf_pkg::job_t            q_job
);

    tscf_pkg::cfg_t                  cfg_reg;
    logic [tscf_pkg::CNT_W-1:0]      cnt_reg, cnt_next, cnt_inc;
    logic                            an_reg, an_next, an_in, an_after;
    logic [1:0]                      run_reg, run_next, run_in, run_calc;
    logic                            is_nl, squeezed, do_num, tab_caret, accept;

    // Saturating BCD increment; an all-nines count stays where it is.
    function automatic logic [tscf_pkg::CNT_W-1:0] bcd_inc(
        input logic [tscf_pkg::CNT_W-1:0] v);
        logic [tscf_pkg::CNT_W-1:0] r;
        logic                       carry;
        logic                       all_nines;
        r         = v;
        carry     = 1'b1;
        all_nines = 1'b1;
        for (int i = 0; i < tscf_pkg::NUM_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd9) all_nines = 1'b0;
        end
        for (int i = 0; i < tscf_pkg::NUM_DIGITS; i++) begin
            if (carry) begin
                if (v[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        if (all_nines) r = v;
        return r;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_nl  = (s_data_byte == tscf_pkg::CH_NL);
        an_in  = s_file_start ? 1'b0 : an_reg;
        run_in = s_file_start ? {1'b0, s_first_file} : run_reg;

        squeezed = cfg_reg.squeeze_blank && is_nl && (run_in >= 2'd2);
        if (cfg_reg.squeeze_blank) begin
            run_calc = is_nl ? run_in + 2'd1 : 2'd0;
        end else begin
            run_calc = run_in;
        end

        do_num = !squeezed && ((cnt_reg == '0) || an_in) &&
                 ((cfg_reg.number_mode == tscf_pkg::NUM_ALL) ||
                  (cfg_reg.number_mode == tscf_pkg::NUM_NONBLANK && !is_nl));
        cnt_inc   = bcd_inc(cnt_reg);
        tab_caret = cfg_reg.show_tabs && (s_data_byte == tscf_pkg::CH_TAB);

        an_after = do_num ? 1'b0 : an_in;
        if (!tab_caret && is_nl) an_after = 1'b1;

        an_next  = an_reg;
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (accept) begin
            // A squeezed newline still takes the file-start reset of the marks.
            an_next  = squeezed ? an_in : an_after;
            run_next = squeezed ? run_in : run_calc;
            cnt_next = do_num ? cnt_inc : cnt_reg;
        end

        q_push       = accept && !squeezed;
        q_job.num_en = do_num;
        q_job.count  = cnt_inc;
        q_job.dollar = cfg_reg.show_ends && is_nl;
        q_job.chr    = tscf_pkg::enc_char(s_data_byte, cfg_reg.show_tabs,
                                          cfg_reg.show_nonprinting);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
            cnt_reg <= '0;
            an_reg  <= 1'b0;
            run_reg <= 2'd1;
        end else begin
            cnt_reg <= cnt_next;
            an_reg  <= an_next;
            run_reg <= run_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    tscf_pkg::REG_NUMBER_MODE:      cfg_reg.number_mode      <= cfg_wdata;
                    tscf_pkg::REG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_wdata[0];
                    tscf_pkg::REG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_wdata[0];
                    tscf_pkg::REG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_wdata[0];
                    tscf_pkg::REG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/tscf_queue.sv @@
// Short job queue that decouples the front end from the output sequencer.
`default_nettype none

module tscf_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire tscf_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output tscf_pkg::job_t      head_job,
    output logic                empty
);

    tscf_pkg::job_t                  mem [tscf_pkg::QDEPTH];
    logic [tscf_pkg::QPTR_W-1:0]     wr_reg, rd_reg;
    logic [tscf_pkg::QPTR_W:0]       cnt_reg;
    logic                            do_push, do_pop;

    assign full     = (cnt_reg == (tscf_pkg::QPTR_W+1)'(tscf_pkg::QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_job = mem[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop)  rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/tscf_back.sv @@
// Back end: expands the queue head job into output bytes, one beat per cycle unless the output is stalled.
`default_nettype none

module tscf_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tscf_pkg::job_t head_job,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_last_of_run
);

    localparam logic [tscf_pkg::POS_W-1:0] P_TAB = tscf_pkg::POS_W'(tscf_pkg::POS_TAB);
    localparam logic [tscf_pkg::POS_W-1:0] P_DOL = tscf_pkg::POS_W'(tscf_pkg::POS_DOL);
    localparam logic [tscf_pkg::POS_W-1:0] P_CHR = tscf_pkg::POS_W'(tscf_pkg::POS_CHR);

    logic                         started_reg;
    logic [tscf_pkg::POS_W-1:0]   idx_reg;
    logic [tscf_pkg::POS_W-1:0]   cur_idx, next_idx, start_idx, chr_ofs;
    logic                         m_valid_reg;
    logic [7:0]                   byte_reg;
    logic                         last_reg;
    logic                         load, is_last, seen;
    logic [7:0]                   cur_byte;
    logic [3:0]                   dig;
    logic [tscf_pkg::NUM_DIGITS-1:0][7:0] dig_ch;

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

    always_comb begin
        // Leading zeros of the line number print as spaces; the last digit always prints.
        seen   = 1'b0;
        dig    = '0;
        dig_ch = '0;
        for (int j = 0; j < tscf_pkg::NUM_DIGITS; j++) begin
            dig = head_job.count[4*(tscf_pkg::NUM_DIGITS-1-j) +: 4];
            if (dig != 4'd0 || j == tscf_pkg::NUM_DIGITS - 1) seen = 1'b1;
            dig_ch[j] = seen ? (tscf_pkg::CH_ZERO + {4'd0, dig}) : tscf_pkg::CH_SPACE;
        end

        if (head_job.num_en) begin
            start_idx = '0;
        end else if (head_job.dollar) begin
            start_idx = P_DOL;
        end else begin
            start_idx = P_CHR;
        end
        cur_idx = started_reg ? idx_reg : start_idx;
        chr_ofs = cur_idx - P_CHR;
        is_last = (cur_idx == P_CHR + {{(tscf_pkg::POS_W-2){1'b0}}, head_job.chr.last});

        if (cur_idx == P_TAB) begin
            next_idx = head_job.dollar ? P_DOL : P_CHR;
        end else begin
            next_idx = cur_idx + 1'b1;
        end

        cur_byte = head_job.chr.b[chr_ofs[1:0]];
        if (cur_idx == P_TAB) begin
            cur_byte = tscf_pkg::CH_TAB;
        end else if (cur_idx == P_DOL) begin
            cur_byte = tscf_pkg::CH_DOLLAR;
        end else begin
            for (int j = 0; j < tscf_pkg::NUM_DIGITS; j++) begin
                if (cur_idx == tscf_pkg::POS_W'(j)) cur_byte = dig_ch[j];
            end
        end

        load  = !q_empty && (!m_valid_reg || m_ready);
        q_pop = load && is_last;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            started_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                started_reg <= !is_last;
                idx_reg     <= next_idx;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/text_stream_cat_filter.sv @@
// Top level of the text stream filter: front end, job queue and output sequencer.
//
//  Port group   Direction  Handshake          Payload
//  s_*          in         s_valid/s_ready    s_data_byte, s_file_start, s_first_file
//  m_*          out        m_valid/m_ready    m_out_byte, m_last_of_run
//  cfg_*        in         cfg_we             cfg_index, cfg_wdata
//
// The front end takes one input beat per cycle while the four-entry job queue has room.
// The output sequencer sends one beat per cycle unless m_ready stalls it, so an input byte
// yields 1 to NUM_DIGITS + 5 output beats (eleven with a six-digit number); a squeezed newline
// yields none. Reset is synchronous; there is no clearing pass.
// A stalled output holds its beat in the output register while the queue keeps filling.
`default_nettype none

module text_stream_cat_filter (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [1:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_file_start,
    input  wire logic       s_first_file,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    tscf_pkg::job_t push_job, head_job;
    logic           q_push, q_full, q_pop, q_empty;

    tscf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_file_start (s_file_start),
        .s_first_file (s_first_file),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    tscf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    tscf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_job      (head_job),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

@@ tb/tb_text_stream_cat_filter.sv @@
// Self-checking testbench for the cat-style text stream filter.
`timescale 1ns / 100ps

module tb_text_stream_cat_filter;

    localparam int LINE_MAX       = 10 ** tscf_pkg::NUM_DIGITS - 1;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_ITEMS    = 75;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } out_beat_t;

    typedef struct {
        logic            set_cfg;
        tscf_pkg::cfg_t  cfg;
        logic [7:0]      data;
        logic            fs;
        logic            ff;
        logic            typed;
        int              n_exp;
        logic [3:0][7:0] exp;
    } stim_row_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [1:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_file_start;
    logic       s_first_file;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    // Filter state as the block should hold it.
    tscf_pkg::cfg_t cfg_model;
    logic [23:0]    line_num;
    logic           after_nl;
    logic [1:0]     nl_run;
    int             item_len;

    out_beat_t   want_q[$];
    out_beat_t   head;
    stim_row_t   stim_tab[$];
    int          fail_count;
    int          idle_cycles;

    text_stream_cat_filter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_file_start  (s_file_start),
        .s_first_file  (s_first_file),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void push_char(input logic [7:0] b);
        want_q.push_back('{b: b, last: 1'b0});
        item_len++;
    endfunction

    function automatic void push_visible(input logic [7:0] c);
        if (c == tscf_pkg::CH_TAB || c == tscf_pkg::CH_NL ||
            (c >= tscf_pkg::CH_SPACE && c < tscf_pkg::CH_DEL)) begin
            push_char(c);
        end else if (c == tscf_pkg::CH_DEL) begin
            push_char(tscf_pkg::CH_CARET);
            push_char(tscf_pkg::CH_QMARK);
        end else if (c >= tscf_pkg::CH_HIGH_PRINT) begin
            push_char(tscf_pkg::CH_UPPER_M);
            push_char(tscf_pkg::CH_DASH);
            if (c == tscf_pkg::CH_HIGH_DEL) begin
                push_char(tscf_pkg::CH_CARET);
                push_char(tscf_pkg::CH_QMARK);
            end else begin
                push_char(c - tscf_pkg::CH_HIGH);
            end
        end else if (c >= tscf_pkg::CH_HIGH) begin
            push_char(tscf_pkg::CH_UPPER_M);
            push_char(tscf_pkg::CH_DASH);
            push_char(tscf_pkg::CH_CARET);
            push_char(c - tscf_pkg::CH_HIGH + tscf_pkg::CARET_OFS);
        end else begin
            push_char(tscf_pkg::CH_CARET);
            push_char(c + tscf_pkg::CARET_OFS);
        end
    endfunction

    // Works out the output beats of one accepted input byte and queues them.
    function automatic void filter_byte(input logic [7:0] c, input logic fs, input logic ff);
        logic            is_nl;
        int unsigned     v;
        logic [7:0]      digit;
        logic [7:0]      field [tscf_pkg::NUM_DIGITS];
        out_beat_t       tail_beat;
        is_nl    = (c == tscf_pkg::CH_NL);
        item_len = 0;
        if (fs) begin
            after_nl = 1'b0;
            nl_run   = ff ? 2'd1 : 2'd0;
        end
        if (cfg_model.squeeze_blank) begin
            if (is_nl) begin
                if (nl_run >= 2'd2) begin
                    return;
                end
                nl_run = nl_run + 2'd1;
            end else begin
                nl_run = 2'd0;
            end
        end
        if ((line_num == '0 || after_nl) &&
            (cfg_model.number_mode == tscf_pkg::NUM_ALL ||
             (cfg_model.number_mode == tscf_pkg::NUM_NONBLANK && !is_nl))) begin
            if (line_num < 24'(LINE_MAX)) begin
                line_num = line_num + 24'd1;
            end
            v = {8'd0, line_num};
            for (int i = tscf_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
                digit = 8'(v % 10);
                field[i] = (v != 0 || i == tscf_pkg::NUM_DIGITS - 1) ?
                           tscf_pkg::CH_ZERO + digit : tscf_pkg::CH_SPACE;
                v = v / 10;
            end
            for (int i = 0; i < tscf_pkg::NUM_DIGITS; i++) begin
                push_char(field[i]);
            end
            push_char(tscf_pkg::CH_TAB);
            after_nl = 1'b0;
        end
        if (cfg_model.show_ends && is_nl) begin
            push_char(tscf_pkg::CH_DOLLAR);
        end
        if (cfg_model.show_tabs && c == tscf_pkg::CH_TAB) begin
            push_char(tscf_pkg::CH_CARET);
            push_char(tscf_pkg::CH_UPPER_I);
        end else begin
            if (is_nl) begin
                after_nl = 1'b1;
            end
            if (cfg_model.show_nonprinting) begin
                push_visible(c);
            end else begin
                push_char(c);
            end
        end
        tail_beat      = want_q.pop_back();
        tail_beat.last = 1'b1;
        want_q.push_back(tail_beat);
    endfunction

    function automatic tscf_pkg::cfg_t make_cfg(input logic [1:0] mode, input logic sq,
                                                input logic ends, input logic tabs,
                                                input logic np);
        tscf_pkg::cfg_t c;
        c.number_mode      = mode;
        c.squeeze_blank    = sq;
        c.show_ends        = ends;
        c.show_tabs        = tabs;
        c.show_nonprinting = np;
        return c;
    endfunction

    function automatic void add_cfg(input tscf_pkg::cfg_t c);
        stim_row_t r;
        r         = '{default: '0};
        r.set_cfg = 1'b1;
        r.cfg     = c;
        stim_tab.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] d, input logic fs, input logic ff);
        stim_row_t r;
        r      = '{default: '0};
        r.data = d;
        r.fs   = fs;
        r.ff   = ff;
        stim_tab.push_back(r);
    endfunction

    // A row whose output is written out by hand, first beat in b0.
    function automatic void add_typed(input logic [7:0] d, input logic fs, input logic ff,
                                      input int n, input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3);
        stim_row_t r;
        r        = '{default: '0};
        r.data   = d;
        r.fs     = fs;
        r.ff     = ff;
        r.typed  = 1'b1;
        r.n_exp  = n;
        r.exp[0] = b0;
        r.exp[1] = b1;
        r.exp[2] = b2;
        r.exp[3] = b3;
        stim_tab.push_back(r);
    endfunction

    // Mostly short gaps, now and then a long one; calm phases never idle.
    function automatic int pick_gap(input logic calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Text-like bytes: lots of printable characters and newlines, some of everything else.
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 8'($urandom_range(32, 126));
        if (r < 72) return tscf_pkg::CH_NL;
        if (r < 79) return tscf_pkg::CH_TAB;
        if (r < 86) return 8'($urandom_range(0, 31));
        if (r < 94) return 8'($urandom_range(127, 255));
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic fs, input logic ff, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= d;
        s_file_start <= fs;
        s_first_file <= ff;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        filter_byte(d, fs, ff);
    endtask

    // Holds the sender off until every expected beat is out and the block has settled.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (want_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input tscf_pkg::cfg_t c);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= tscf_pkg::REG_NUMBER_MODE;
        cfg_wdata <= c.number_mode;
        @(negedge aclk);
        cfg_index <= tscf_pkg::REG_SQUEEZE_BLANK;
        cfg_wdata <= {1'b0, c.squeeze_blank};
        @(negedge aclk);
        cfg_index <= tscf_pkg::REG_SHOW_ENDS;
        cfg_wdata <= {1'b0, c.show_ends};
        @(negedge aclk);
        cfg_index <= tscf_pkg::REG_SHOW_TABS;
        cfg_wdata <= {1'b0, c.show_tabs};
        @(negedge aclk);
        cfg_index <= tscf_pkg::REG_SHOW_NONPRINTING;
        cfg_wdata <= {1'b0, c.show_nonprinting};
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_model = c;
    endtask

    // Output side: bursts of readiness broken by stalls of random length.
    initial begin
        int run_len;
        int stall;
        m_ready = 1'b0;
        forever begin
            run_len = $urandom_range(1, 40);
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat (run_len - 1) @(negedge aclk);
            stall = pick_gap(1'b0);
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat 0x%02h last %0b",
                                        m_out_byte, m_last_of_run));
            end else begin
                head = want_q.pop_front();
                if (m_out_byte !== head.b) begin
                    flag_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                            m_out_byte, head.b));
                end
                if (m_last_of_run !== head.last) begin
                    flag_mismatch($sformatf("last_of_run %0b, expected %0b on byte 0x%02h",
                                            m_last_of_run, head.last, head.b));
                end
            end
        end
    end

    // Only expected output beats count as progress, so a runaway output cannot keep it alive.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_valid && s_ready) ||
            (m_valid && m_ready && want_q.size() != 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_text_stream_cat_filter NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        stim_row_t      row;
        tscf_pkg::cfg_t phase_cfg;
        logic           calm;
        logic [7:0]     d;
        logic           fs;
        logic           ff;

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = tscf_pkg::REG_NUMBER_MODE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        s_file_start = 1'b0;
        s_first_file = 1'b0;
        fail_count   = 0;
        idle_cycles  = 0;
        cfg_model    = make_cfg(tscf_pkg::NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
        line_num     = '0;
        after_nl     = 1'b0;
        nl_run       = 2'd1;

        // Registers left at their reset values: bytes pass straight through.
        add_typed("A", 1'b1, 1'b1, 1, "A", 8'h00, 8'h00, 8'h00);
        add_typed(8'h00, 1'b0, 1'b0, 1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_typed(8'hFF, 1'b0, 1'b0, 1, 8'hFF, 8'h00, 8'h00, 8'h00);
        add_typed(tscf_pkg::CH_NL, 1'b0, 1'b0, 1, tscf_pkg::CH_NL, 8'h00, 8'h00, 8'h00);
        // Everything on: numbering, squeezing, ends, tabs and caret notation.
        add_cfg(make_cfg(tscf_pkg::NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1));
        add_byte(tscf_pkg::CH_TAB, 1'b1, 1'b0);
        add_typed(tscf_pkg::CH_DEL, 1'b0, 1'b0, 2, tscf_pkg::CH_CARET, tscf_pkg::CH_QMARK,
                  8'h00, 8'h00);
        add_typed(tscf_pkg::CH_HIGH, 1'b0, 1'b0, 4, tscf_pkg::CH_UPPER_M, tscf_pkg::CH_DASH,
                  tscf_pkg::CH_CARET, "@");
        add_typed(tscf_pkg::CH_HIGH_PRINT, 1'b0, 1'b0, 3, tscf_pkg::CH_UPPER_M,
                  tscf_pkg::CH_DASH, tscf_pkg::CH_SPACE, 8'h00);
        add_typed(tscf_pkg::CH_HIGH_DEL, 1'b0, 1'b0, 4, tscf_pkg::CH_UPPER_M,
                  tscf_pkg::CH_DASH, tscf_pkg::CH_CARET, tscf_pkg::CH_QMARK);
        add_typed(8'h01, 1'b0, 1'b0, 2, tscf_pkg::CH_CARET, "A", 8'h00, 8'h00);
        add_typed(8'h00, 1'b0, 1'b0, 2, tscf_pkg::CH_CARET, "@", 8'h00, 8'h00);
        add_byte(tscf_pkg::CH_NL, 1'b0, 1'b0);
        add_byte(tscf_pkg::CH_NL, 1'b0, 1'b0);
        // A third newline in a row is squeezed away and yields no beat.
        add_typed(tscf_pkg::CH_NL, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        // A later file clears the line-start mark, so its first line goes unnumbered.
        add_typed("z", 1'b1, 1'b1, 1, "z", 8'h00, 8'h00, 8'h00);
        add_byte(tscf_pkg::CH_NL, 1'b1, 1'b1);
        add_typed(tscf_pkg::CH_NL, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        // Non-blank numbering with caret notation but tabs passed through.
        add_cfg(make_cfg(tscf_pkg::NUM_NONBLANK, 1'b0, 1'b0, 1'b0, 1'b1));
        add_byte(tscf_pkg::CH_NL, 1'b0, 1'b0);
        add_byte(tscf_pkg::CH_TAB, 1'b0, 1'b0);
        add_typed(8'h9F, 1'b0, 1'b0, 4, tscf_pkg::CH_UPPER_M, tscf_pkg::CH_DASH,
                  tscf_pkg::CH_CARET, "_");
        add_typed(8'h1F, 1'b0, 1'b0, 2, tscf_pkg::CH_CARET, "_", 8'h00, 8'h00);
        // The unused numbering code acts as no numbering.
        add_cfg(make_cfg(2'd3, 1'b0, 1'b1, 1'b0, 1'b0));
        add_typed(tscf_pkg::CH_NL, 1'b0, 1'b0, 2, tscf_pkg::CH_DOLLAR, tscf_pkg::CH_NL,
                  8'h00, 8'h00);
        add_typed("q", 1'b0, 1'b0, 1, "q", 8'h00, 8'h00, 8'h00);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_tab[r]) begin
            row = stim_tab[r];
            if (row.set_cfg) begin
                wait_idle();
                write_cfg(row.cfg);
            end else begin
                send_byte(row.data, row.fs, row.ff, pick_gap(1'b0));
                if (row.typed) begin
                    // Replace the computed beats of this byte by the ones written out.
                    repeat (item_len) void'(want_q.pop_back());
                    for (int k = 0; k < row.n_exp; k++) begin
                        want_q.push_back('{b: row.exp[k], last: (k == row.n_exp - 1)});
                    end
                end
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: phase_cfg = make_cfg(tscf_pkg::NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1);
                1: phase_cfg = make_cfg(tscf_pkg::NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
                2: phase_cfg = make_cfg(tscf_pkg::NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
                default: phase_cfg = make_cfg(2'($urandom_range(0, 3)), 1'($urandom),
                                              1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            wait_idle();
            write_cfg(phase_cfg);
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 59) == 0) begin
                    wait_idle();
                end
                d  = pick_text_byte();
                fs = ($urandom_range(0, 29) == 0);
                ff = 1'($urandom);
                send_byte(d, fs, ff, pick_gap(calm));
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && want_q.size() == 0) begin
            $display("tb_text_stream_cat_filter OK");
        end else begin
            $display("tb_text_stream_cat_filter NOT OK");
        end
        $finish;
    end

endmodule
